// ===== rtl/core/cdg_pkg.sv =====
// Shared types, widths and constants for the civil date to GPS week/time block.
// No dependencies; every other file of the block takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package cdg_pkg;

   // Field widths
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SEC_W    = 22;
   localparam int unsigned WEEK_W   = 14;
   localparam int unsigned SOW_W    = 36;
   localparam int unsigned FRAC_W   = 16;

   // Internal widths: running week count covers years up to 4095
   localparam int unsigned WCNT_W   = 17;
   localparam int unsigned REM_W    = 3;
   localparam int unsigned TOD_W    = 20;

   // Epoch and calendar constants
   localparam int unsigned EPOCH_YEAR      = 1980;
   localparam int unsigned EPOCH_DAY       = 6;
   localparam int unsigned WEEK_MAX        = 16383;
   localparam int unsigned DAYS_PER_WEEK   = 7;
   localparam int unsigned WEEKS_PER_YEAR  = 52;
   localparam int unsigned WEEKS_PER_MONTH = 4;
   localparam int unsigned SHORTEST_MONTH  = 28;
   localparam int unsigned SEC_PER_DAY     = 86400;
   localparam int unsigned SEC_PER_HOUR    = 3600;
   localparam int unsigned SEC_PER_MINUTE  = 60;
   localparam int unsigned FEBRUARY        = 2;
   localparam int unsigned DECEMBER        = 12;

   // Leap-rule phase counters start at the epoch year
   localparam int unsigned MOD4_INIT   = EPOCH_YEAR % 4;
   localparam int unsigned MOD100_INIT = EPOCH_YEAR % 100;
   localparam int unsigned MOD400_INIT = EPOCH_YEAR % 400;

   typedef struct packed {
      logic load;        // capture a new input beat
      logic step_year;   // add one whole year
      logic step_month;  // add one whole month
      logic add_day;     // add the day of month
      logic sub_epoch;   // remove the epoch day offset
      logic finish;      // build the result registers
   } cdg_cmd_type;

   typedef struct packed {
      logic before_epoch;
      logic years_done;
      logic months_done;
   } cdg_status_type;

   // Length of a month other than February, 1 = January
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
      logic [4:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdg_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on cdg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdg_req_if;
   logic                             valid;
   logic                             ready;
   logic [cdg_pkg::YEAR_W-1:0]       year;
   logic [cdg_pkg::MONTH_W-1:0]      month;
   logic [cdg_pkg::DAY_W-1:0]        day;
   logic [cdg_pkg::HOUR_W-1:0]       hour;
   logic [cdg_pkg::MINUTE_W-1:0]     minute;
   logic [cdg_pkg::SEC_W-1:0]        second_fixed;

   modport source (output valid, year, month, day, hour, minute, second_fixed,
                   input ready);
   modport sink   (input valid, year, month, day, hour, minute, second_fixed,
                   output ready);
endinterface

interface cdg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cdg_pkg::WEEK_W-1:0]   gps_week;
   logic [cdg_pkg::SOW_W-1:0]    seconds_of_week;
   logic                         before_epoch;

   modport source (output valid, gps_week, seconds_of_week, before_epoch,
                   input ready);
   modport sink   (input valid, gps_week, seconds_of_week, before_epoch,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cdg_dp.sv =====
// Datapath: input capture, year/month/day accumulation as weeks plus day
// remainder, leap-rule counters and result registers. Depends on cdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdg_dp (
   input  wire                                clock,
   input  cdg_pkg::cdg_cmd_type               cmd,
   output cdg_pkg::cdg_status_type            status,
   input  wire [cdg_pkg::YEAR_W-1:0]          in_year,
   input  wire [cdg_pkg::MONTH_W-1:0]         in_month,
   input  wire [cdg_pkg::DAY_W-1:0]           in_day,
   input  wire [cdg_pkg::HOUR_W-1:0]          in_hour,
   input  wire [cdg_pkg::MINUTE_W-1:0]        in_minute,
   input  wire [cdg_pkg::SEC_W-1:0]           in_second,
   output logic [cdg_pkg::WEEK_W-1:0]         out_week,
   output logic [cdg_pkg::SOW_W-1:0]          out_sow,
   output logic                               out_before
);

   logic [cdg_pkg::YEAR_W-1:0]   year_ff, ycnt_ff, ycnt_in;
   logic [cdg_pkg::MONTH_W-1:0]  month_ff, mcnt_ff, mcnt_in;
   logic [cdg_pkg::DAY_W-1:0]    day_ff;
   logic [cdg_pkg::HOUR_W-1:0]   hour_ff;
   logic [cdg_pkg::MINUTE_W-1:0] minute_ff;
   logic [cdg_pkg::SEC_W-1:0]    sec_ff;
   logic                         epoch_ff;
   logic [1:0]                   m4_ff, m4_in;
   logic [6:0]                   m100_ff, m100_in;
   logic [8:0]                   m400_ff, m400_in;
   logic [cdg_pkg::WCNT_W-1:0]   week_ff, week_in;
   logic [cdg_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [cdg_pkg::WEEK_W-1:0]   out_week_ff, out_week_in;
   logic [cdg_pkg::SOW_W-1:0]    out_sow_ff, out_sow_in;
   logic                         out_before_ff;

   logic                         leap;
   logic                         in_before;
   logic [cdg_pkg::MONTH_W-1:0]  month_clamp;
   logic [5:0]                   add_w;
   logic [cdg_pkg::REM_W-1:0]    add_r;
   logic [4:0]                   mlen;
   logic [2:0]                   day_q;
   logic [3:0]                   rem_sum;
   logic                         carry;
   logic [cdg_pkg::TOD_W-1:0]    tod;

   assign leap = (m400_ff == 9'd0) || ((m4_ff == 2'd0) && (m100_ff != 7'd0));

   assign in_before = (in_year < cdg_pkg::YEAR_W'(cdg_pkg::EPOCH_YEAR)) ||
                      ((in_year == cdg_pkg::YEAR_W'(cdg_pkg::EPOCH_YEAR)) &&
                       (in_month <= 4'd1) &&
                       (in_day < cdg_pkg::DAY_W'(cdg_pkg::EPOCH_DAY)));

   assign month_clamp = (in_month > cdg_pkg::MONTH_W'(cdg_pkg::DECEMBER)) ?
                        cdg_pkg::MONTH_W'(cdg_pkg::DECEMBER) : in_month;

   assign status.before_epoch = epoch_ff;
   assign status.years_done   = (ycnt_ff == year_ff);
   assign status.months_done  = (mcnt_ff >= month_ff);

   // Split the day of month into whole weeks and leftover days
   assign day_q = 3'(day_ff >= 5'd7) + 3'(day_ff >= 5'd14) +
                  3'(day_ff >= 5'd21) + 3'(day_ff >= 5'd28);

   always_comb begin
      mlen = cdg_pkg::month_len(mcnt_ff);
      if (mcnt_ff == cdg_pkg::MONTH_W'(cdg_pkg::FEBRUARY)) begin
         mlen = leap ? 5'd29 : 5'd28;
      end
      add_w = 6'd0;
      add_r = '0;
      if (cmd.step_year) begin
         add_w = 6'(cdg_pkg::WEEKS_PER_YEAR);
         add_r = leap ? 3'd2 : 3'd1;
      end else if (cmd.step_month) begin
         add_w = 6'(cdg_pkg::WEEKS_PER_MONTH);
         add_r = 3'(mlen - 5'(cdg_pkg::SHORTEST_MONTH));
      end else if (cmd.add_day) begin
         add_w = 6'(day_q);
         add_r = 3'(day_ff - 5'(day_q) * 5'd7);
      end
      rem_sum = {1'b0, rem_ff} + {1'b0, add_r};
      carry   = (rem_sum >= 4'(cdg_pkg::DAYS_PER_WEEK));
   end

   always_comb begin
      ycnt_in = ycnt_ff;
      mcnt_in = mcnt_ff;
      m4_in   = m4_ff;
      m100_in = m100_ff;
      m400_in = m400_ff;
      week_in = week_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         ycnt_in = cdg_pkg::YEAR_W'(cdg_pkg::EPOCH_YEAR);
         mcnt_in = 4'd1;
         m4_in   = 2'(cdg_pkg::MOD4_INIT);
         m100_in = 7'(cdg_pkg::MOD100_INIT);
         m400_in = 9'(cdg_pkg::MOD400_INIT);
         week_in = '0;
         rem_in  = '0;
      end else if (cmd.sub_epoch) begin
         // total is at least the epoch offset here, so the week never wraps
         if (rem_ff >= 3'(cdg_pkg::EPOCH_DAY)) begin
            rem_in = rem_ff - 3'(cdg_pkg::EPOCH_DAY);
         end else begin
            rem_in  = rem_ff + 3'(cdg_pkg::DAYS_PER_WEEK - cdg_pkg::EPOCH_DAY);
            week_in = week_ff - cdg_pkg::WCNT_W'(1);
         end
      end else if (cmd.step_year || cmd.step_month || cmd.add_day) begin
         rem_in  = carry ? 3'(rem_sum - 4'(cdg_pkg::DAYS_PER_WEEK)) : rem_sum[2:0];
         week_in = week_ff + cdg_pkg::WCNT_W'(add_w) + cdg_pkg::WCNT_W'(carry);
         if (cmd.step_year) begin
            ycnt_in = ycnt_ff + 12'd1;
            m4_in   = m4_ff + 2'd1;
            m100_in = (m100_ff == 7'd99)  ? 7'd0 : m100_ff + 7'd1;
            m400_in = (m400_ff == 9'd399) ? 9'd0 : m400_ff + 9'd1;
         end
         if (cmd.step_month) begin
            mcnt_in = mcnt_ff + 4'd1;
         end
      end
   end

   // Seconds into the week from day remainder, hour and minute, not normalized
   assign tod = cdg_pkg::TOD_W'(rem_ff) * cdg_pkg::TOD_W'(cdg_pkg::SEC_PER_DAY) +
                cdg_pkg::TOD_W'(hour_ff) * cdg_pkg::TOD_W'(cdg_pkg::SEC_PER_HOUR) +
                cdg_pkg::TOD_W'(minute_ff) * cdg_pkg::TOD_W'(cdg_pkg::SEC_PER_MINUTE);

   always_comb begin
      out_week_in = '0;
      out_sow_in  = '0;
      if (!epoch_ff) begin
         out_week_in = (week_ff > cdg_pkg::WCNT_W'(cdg_pkg::WEEK_MAX)) ?
                       cdg_pkg::WEEK_W'(cdg_pkg::WEEK_MAX) : week_ff[cdg_pkg::WEEK_W-1:0];
         out_sow_in  = (cdg_pkg::SOW_W'(tod) << cdg_pkg::FRAC_W) +
                       cdg_pkg::SOW_W'(sec_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff   <= in_year;
         month_ff  <= month_clamp;
         day_ff    <= in_day;
         hour_ff   <= in_hour;
         minute_ff <= in_minute;
         sec_ff    <= in_second;
         epoch_ff  <= in_before;
      end
      ycnt_ff <= ycnt_in;
      mcnt_ff <= mcnt_in;
      m4_ff   <= m4_in;
      m100_ff <= m100_in;
      m400_ff <= m400_in;
      week_ff <= week_in;
      rem_ff  <= rem_in;
      if (cmd.finish) begin
         out_week_ff   <= out_week_in;
         out_sow_ff    <= out_sow_in;
         out_before_ff <= epoch_ff;
      end
   end

   assign out_week   = out_week_ff;
   assign out_sow    = out_sow_ff;
   assign out_before = out_before_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cdg_ctrl.sv =====
// Controller: sequences one conversion through years, months, day, epoch
// offset and result (a pre-epoch date skips to the result); owns the handshake flags. Depends on cdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdg_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   input  cdg_pkg::cdg_status_type   status,
   output cdg_pkg::cdg_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_YEARS,
      S_MONTHS,
      S_DAY,
      S_EPOCH,
      S_FINISH,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == S_IDLE) && req_valid;
      cmd.step_year  = (state_ff == S_YEARS) && !status.before_epoch &&
                       !status.years_done;
      cmd.step_month = (state_ff == S_MONTHS) && !status.months_done;
      cmd.add_day    = (state_ff == S_DAY);
      cmd.sub_epoch  = (state_ff == S_EPOCH);
      cmd.finish     = (state_ff == S_FINISH);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_YEARS;
            end
            S_YEARS: begin
               if (status.before_epoch) state_ff <= S_FINISH;
               else if (status.years_done) state_ff <= S_MONTHS;
            end
            S_MONTHS: begin
               if (status.months_done) state_ff <= S_DAY;
            end
            S_DAY: begin
               state_ff <= S_EPOCH;
            end
            S_EPOCH: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               state_ff     <= S_OUT;
               rsp_valid_ff <= 1'b1;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/civil_date_to_gps_week_time.sv =====
// Top level: civil date and time to GPS week and seconds of week.
// Depends on cdg_pkg, cdg_if (channels), cdg_ctrl and cdg_dp.
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+-------------------------------------------
//   req_ch  | in        | valid/ready       | year, month, day, hour, minute, second_fixed
//   rsp_ch  | out       | valid/ready       | gps_week, seconds_of_week, before_epoch
//
// Timing: the time from accept to rsp valid is set by the year loop, which adds
// one year per cycle through the shared week/remainder adder, and by the month
// loop. A date before the epoch skips both loops and goes straight to the result.
// Reset is synchronous and active high; it clears the controller only.
// One beat is in flight at a time: req ready drops at accept and comes back
// once the response beat has been taken, so a stalled rsp holds everything.
`timescale 1ns / 1ps
`default_nettype none

module civil_date_to_gps_week_time (
   input wire         clock,
   input wire         reset,
   cdg_req_if.sink    req_ch,
   cdg_rsp_if.source  rsp_ch
);

   cdg_pkg::cdg_cmd_type    cmd;
   cdg_pkg::cdg_status_type status;

   // Sequencer: walks years, months, day and epoch offset, then presents the beat
   cdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Day count held as whole weeks plus a 0..6 day remainder, so the week
   // number needs no divider; the result registers hold the response payload
   cdg_dp u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .in_year    (req_ch.year),
      .in_month   (req_ch.month),
      .in_day     (req_ch.day),
      .in_hour    (req_ch.hour),
      .in_minute  (req_ch.minute),
      .in_second  (req_ch.second_fixed),
      .out_week   (rsp_ch.gps_week),
      .out_sow    (rsp_ch.seconds_of_week),
      .out_before (rsp_ch.before_epoch)
   );

   // Never take a new beat while a response is waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken while response pending");

   // Pre-epoch dates must give zero week and seconds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.before_epoch) |->
         (rsp_ch.gps_week == '0) && (rsp_ch.seconds_of_week == '0))
      else $error("pre-epoch response carries nonzero time");

   // A response never appears in the cycle right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !rsp_ch.valid)
      else $error("response raised without any conversion work");

   // Response week and seconds of week hold while it waits to be taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
         $stable(rsp_ch.gps_week) && $stable(rsp_ch.seconds_of_week))
      else $error("response payload changed while stalled");

endmodule

`default_nettype wire
